/* src/hsl_to_rgb_converter_core_assert.svh */
// Assertion macros for the HSL to RGB converter core.
`ifndef HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define HSL2RGB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsl2rgb: same-cycle check failed");
// Next-cycle implication
`define HSL2RGB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsl2rgb: next-cycle check failed");
`else
`define HSL2RGB_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HSL2RGB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/hsl2rgb_pkg.sv */
// Shared constants and types of the HSL to RGB converter core.
package hsl2rgb_pkg;

   // Field widths and packing of the stream words
   localparam int HUE_W    = 18;
   localparam int FRAC_W   = 13;
   localparam int CHAN_W   = 8;
   localparam int HUE_LSB  = 0;
   localparam int SAT_LSB  = HUE_LSB + HUE_W;
   localparam int LIG_LSB  = SAT_LSB + FRAC_W;
   localparam int OPA_LSB  = LIG_LSB + FRAC_W;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;

   // Full-scale channel level
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   // Register stages from accepted input to output register
   localparam int STAGE_COUNT = 8;

   // Per-stage control from the stage controller
   typedef struct packed {
      logic [STAGE_COUNT-1:0] load;
      logic [STAGE_COUNT-1:0] valid;
   } pipe_ctl_type;

endpackage

/* src/hsl2rgb_stage_ctrl.sv */
// Valid/load control of the converter pipeline with bubble collapsing.
`include "hsl_to_rgb_converter_core_assert.svh"

module hsl2rgb_stage_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      out_ready,
   output hsl2rgb_pkg::pipe_ctl_type ctl
);

   localparam int LAST = hsl2rgb_pkg::STAGE_COUNT - 1;

   logic [LAST:0] valid_ff;
   logic [LAST:0] valid_in;
   logic [LAST:0] load;
   logic          in_acc;
   logic          out_acc;

   // A stage may load when empty or when the stage after it moves on
   always_comb begin
      load[LAST] = !valid_ff[LAST] || out_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i + 1];
      end
   end

   // Valid bits follow the data
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i <= LAST; i++) begin
         if (load[i]) begin
            valid_in[i] = (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = load[0];
   assign in_acc    = in_valid && load[0];
   assign out_acc   = valid_ff[LAST] && out_ready;
   assign ctl.load  = load;
   assign ctl.valid = valid_ff;

   // Input is refused only when every stage holds an item
   `HSL2RGB_ASSERT_NOW(a_full_when_blocked, clock, reset, !in_ready, &valid_ff)
   // A transfer in always lands in the first stage
   `HSL2RGB_ASSERT_NEXT(a_first_stage_fill, clock, reset, in_acc, valid_ff[0])
   // Occupancy moves only by transfers in and out
   `HSL2RGB_ASSERT_NEXT(a_occupancy, clock, reset, 1'b1, ($countones(valid_ff) == $past($countones(valid_ff)) + $past(32'(in_acc)) - $past(32'(out_acc))))

endmodule

/* src/hsl2rgb_round.sv */
// Final rounding of one channel: round(num * 255 / den), halves up, clamped to 0..255.
module hsl2rgb_round #(
   parameter int NUM_W = 45,
   parameter int SHIFT = 33
) (
   input  logic signed [NUM_W-1:0]                num,
   output logic [hsl2rgb_pkg::CHAN_W-1:0] level
);

   localparam int SC_W = NUM_W + 6;
   localparam logic signed [SC_W-1:0] HALF = SC_W'(1) <<< (SHIFT - 1);

   logic signed [SC_W-1:0] scaled;
   logic signed [SC_W-1:0] quot;

   // The scale 255/den reduces to 17 / 2^SHIFT, so no divider is needed
   always_comb begin
      scaled = (SC_W'(num) <<< 4) + SC_W'(num) + HALF;
      quot   = scaled >>> SHIFT;
      if (scaled[SC_W-1]) begin
         level = '0;
      end else if (quot > SC_W'(255)) begin
         level = hsl2rgb_pkg::CHAN_MAX;
      end else begin
         level = quot[hsl2rgb_pkg::CHAN_W-1:0];
      end
   end

endmodule

/* src/hsl_to_rgb_converter_core.sv */
// HSL to RGB converter core: eight register stages, one item per clock unless the output stalls.
// The input transfer loads the first stage; rsp_tvalid is the valid bit of the last stage.
// Each stage holds about one multiply or one short add chain.
// A stalled output holds its stage, and earlier stages keep filling until no bubble remains.
// Reset (synchronous, active high) clears only the stage valid bits; no memories to sweep.
`include "hsl_to_rgb_converter_core_assert.svh"

module hsl_to_rgb_converter_core #(
   parameter int FRACTION_BITS     = 12,
   parameter int HUE_FRACTION_BITS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // hue[17:0], saturation[30:18], lightness[43:31], opacity[56:44], zeros above
   input  logic [hsl2rgb_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
   output logic [hsl2rgb_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int F      = FRACTION_BITS;
   localparam int H      = HUE_FRACTION_BITS;
   localparam int HUE_W  = hsl2rgb_pkg::HUE_W;
   localparam int FRAC_W = hsl2rgb_pkg::FRAC_W;
   localparam int CHAN_W = hsl2rgb_pkg::CHAN_W;

   // Hue geometry
   localparam int SEC_W   = 60 << H;
   localparam int PERIOD  = 6 * SEC_W;
   localparam int REM_W   = $clog2(PERIOD);
   localparam int RP_W    = REM_W + 1;
   localparam int WI_W    = H + 6;
   localparam int K       = HUE_W + REM_W;
   localparam int RECIP_W = HUE_W + 1;
   localparam int QW      = HUE_W + 1 - REM_W;
   localparam int PROD_W  = HUE_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << K) / PERIOD);

   // Chroma and channel arithmetic
   localparam int ONE   = 1 << F;
   localparam int DEV_W = ((F > 14) ? F : 14) + 2;
   localparam int CN_W  = DEV_W + FRAC_W + 1;
   localparam int CO_W  = H + 8;
   localparam int PR_W  = CN_W + CO_W;
   localparam int LW_W  = FRAC_W + H + 6;
   localparam int BASE_W = LW_W + F + 1;
   localparam int NUM_W = ((PR_W > BASE_W) ? PR_W : BASE_W) + 1;
   localparam int SHIFT = 2 * F + H + 3;
   localparam int AL_W  = FRAC_W + 9;

   hsl2rgb_pkg::pipe_ctl_type ctl;

   // ---------------- stage 1: hue magnitude times reciprocal, chroma factor, alpha
   logic [HUE_W-1:0]        hue_raw;
   logic                    neg_in;
   logic [HUE_W-1:0]        mag_in;
   logic [FRAC_W-1:0]       sat_raw;
   logic [FRAC_W-1:0]       lig_raw;
   logic [FRAC_W-1:0]       opa_raw;
   logic [PROD_W-1:0]       hprod_in;
   logic signed [DEV_W-1:0] dev;
   logic signed [DEV_W-1:0] adev;
   logic signed [DEV_W-1:0] cf_in;
   logic [LW_W-1:0]         lw_in;
   logic [AL_W-1:0]         al_sum;
   logic [AL_W-1:0]         al_sh;
   logic [CHAN_W-1:0]       alpha_in;

   always_comb begin
      hue_raw  = req_tdata[hsl2rgb_pkg::HUE_LSB +: HUE_W];
      sat_raw  = req_tdata[hsl2rgb_pkg::SAT_LSB +: FRAC_W];
      lig_raw  = req_tdata[hsl2rgb_pkg::LIG_LSB +: FRAC_W];
      opa_raw  = req_tdata[hsl2rgb_pkg::OPA_LSB +: FRAC_W];
      neg_in   = hue_raw[HUE_W-1];
      mag_in   = neg_in ? (~hue_raw + 1'b1) : hue_raw;
      hprod_in = PROD_W'(mag_in) * PROD_W'(RECIP);
      dev      = DEV_W'({lig_raw, 1'b0}) - DEV_W'(ONE);
      adev     = dev[DEV_W-1] ? -dev : dev;
      cf_in    = DEV_W'(ONE) - adev;
      lw_in    = LW_W'(lig_raw) * LW_W'(SEC_W);
      al_sum   = AL_W'(opa_raw) * AL_W'(255) + AL_W'(ONE >> 1);
      al_sh    = al_sum >> F;
      alpha_in = (al_sh > AL_W'(255)) ? hsl2rgb_pkg::CHAN_MAX : al_sh[CHAN_W-1:0];
   end

   logic                    neg_s1_ff;
   logic [HUE_W-1:0]        mag_s1_ff;
   logic [PROD_W-1:0]       hprod_s1_ff;
   logic signed [DEV_W-1:0] cf_s1_ff;
   logic [FRAC_W-1:0]       sat_s1_ff;
   logic [LW_W-1:0]         lw_s1_ff;
   logic [CHAN_W-1:0]       alpha_s1_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         neg_s1_ff   <= neg_in;
         mag_s1_ff   <= mag_in;
         hprod_s1_ff <= hprod_in;
         cf_s1_ff    <= cf_in;
         sat_s1_ff   <= sat_raw;
         lw_s1_ff    <= lw_in;
         alpha_s1_ff <= alpha_in;
      end
   end

   // ---------------- stage 2: approximate remainder, chroma numerator
   logic [QW-1:0]          quo_est;
   logic [HUE_W-1:0]       quo_prod;
   logic [HUE_W-1:0]       rp_full;
   logic signed [CN_W-1:0] cn_in;

   always_comb begin
      quo_est  = hprod_s1_ff[K +: QW];
      quo_prod = HUE_W'(quo_est) * HUE_W'(PERIOD);
      rp_full  = mag_s1_ff - quo_prod;
      cn_in    = CN_W'(cf_s1_ff) * CN_W'(signed'({1'b0, sat_s1_ff}));
   end

   logic                   neg_s2_ff;
   logic [RP_W-1:0]        rp_s2_ff;
   logic signed [CN_W-1:0] cn_s2_ff;
   logic [LW_W-1:0]        lw_s2_ff;
   logic [CHAN_W-1:0]      alpha_s2_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         neg_s2_ff   <= neg_s1_ff;
         rp_s2_ff    <= rp_full[RP_W-1:0];
         cn_s2_ff    <= cn_in;
         lw_s2_ff    <= lw_s1_ff;
         alpha_s2_ff <= alpha_s1_ff;
      end
   end

   // ---------------- stage 3: remainder correction, sign handling
   logic [REM_W-1:0] rem_in;
   logic             nosect_in;

   always_comb begin
      if (rp_s2_ff >= RP_W'(PERIOD)) begin
         rem_in = REM_W'(rp_s2_ff - RP_W'(PERIOD));
      end else begin
         rem_in = REM_W'(rp_s2_ff);
      end
      // negative remainder lies in no sector
      nosect_in = neg_s2_ff && (rem_in != '0);
   end

   logic [REM_W-1:0]       rem_s3_ff;
   logic                   nosect_s3_ff;
   logic signed [CN_W-1:0] cn_s3_ff;
   logic [LW_W-1:0]        lw_s3_ff;
   logic [CHAN_W-1:0]      alpha_s3_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         rem_s3_ff    <= rem_in;
         nosect_s3_ff <= nosect_in;
         cn_s3_ff     <= cn_s2_ff;
         lw_s3_ff     <= lw_s2_ff;
         alpha_s3_ff  <= alpha_s2_ff;
      end
   end

   // ---------------- stage 4: sector and position within it
   logic [2:0]       sector_in;
   logic [REM_W-1:0] sec_base;
   logic [WI_W-1:0]  within_in;

   always_comb begin
      sector_in = '0;
      sec_base  = '0;
      for (int k = 1; k < 6; k++) begin
         if (rem_s3_ff >= REM_W'(k * SEC_W)) begin
            sector_in = 3'(k);
            sec_base  = REM_W'(k * SEC_W);
         end
      end
      within_in = WI_W'(rem_s3_ff - sec_base);
   end

   logic [2:0]             sector_s4_ff;
   logic [WI_W-1:0]        within_s4_ff;
   logic                   nosect_s4_ff;
   logic signed [CN_W-1:0] cn_s4_ff;
   logic [LW_W-1:0]        lw_s4_ff;
   logic [CHAN_W-1:0]      alpha_s4_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         sector_s4_ff <= sector_in;
         within_s4_ff <= within_in;
         nosect_s4_ff <= nosect_s3_ff;
         cn_s4_ff     <= cn_s3_ff;
         lw_s4_ff     <= lw_s3_ff;
         alpha_s4_ff  <= alpha_s3_ff;
      end
   end

   // ---------------- stage 5: per-channel coefficient (k - width)
   logic [WI_W-1:0]        tri_pos;
   logic signed [CO_W-1:0] c_full;
   logic signed [CO_W-1:0] c_none;
   logic signed [CO_W-1:0] c_part;
   logic signed [CO_W-1:0] coef_in [3];

   always_comb begin
      tri_pos = sector_s4_ff[0] ? (WI_W'(SEC_W) - within_s4_ff) : within_s4_ff;
      c_full  = CO_W'(SEC_W);
      c_none  = -c_full;
      c_part  = CO_W'({tri_pos, 1'b0}) - c_full;
      coef_in[0] = c_none;
      coef_in[1] = c_none;
      coef_in[2] = c_none;
      if (!nosect_s4_ff) begin
         case (sector_s4_ff)
            3'd0: begin
               coef_in[0] = c_full;
               coef_in[1] = c_part;
            end
            3'd1: begin
               coef_in[0] = c_part;
               coef_in[1] = c_full;
            end
            3'd2: begin
               coef_in[1] = c_full;
               coef_in[2] = c_part;
            end
            3'd3: begin
               coef_in[1] = c_part;
               coef_in[2] = c_full;
            end
            3'd4: begin
               coef_in[0] = c_part;
               coef_in[2] = c_full;
            end
            default: begin
               coef_in[0] = c_full;
               coef_in[2] = c_part;
            end
         endcase
      end
   end

   logic signed [CO_W-1:0] coef_s5_ff [3];
   logic                   nosect_s5_ff;
   logic signed [CN_W-1:0] cn_s5_ff;
   logic [LW_W-1:0]        lw_s5_ff;
   logic [CHAN_W-1:0]      alpha_s5_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         coef_s5_ff   <= coef_in;
         nosect_s5_ff <= nosect_s4_ff;
         cn_s5_ff     <= cn_s4_ff;
         lw_s5_ff     <= lw_s4_ff;
         alpha_s5_ff  <= alpha_s4_ff;
      end
   end

   // ---------------- stage 6: chroma times coefficient
   logic signed [PR_W-1:0] prod_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = PR_W'(cn_s5_ff) * PR_W'(coef_s5_ff[c]);
      end
   end

   logic signed [PR_W-1:0] prod_s6_ff [3];
   logic [LW_W-1:0]        lw_s6_ff;
   logic [CHAN_W-1:0]      alpha_s6_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         prod_s6_ff  <= prod_in;
         lw_s6_ff    <= lw_s5_ff;
         alpha_s6_ff <= alpha_s5_ff;
      end
   end

   // ---------------- stage 7: add the lightness term
   logic signed [NUM_W-1:0] light_term;
   logic signed [NUM_W-1:0] num_in [3];

   always_comb begin
      light_term = NUM_W'(lw_s6_ff) << (F + 1);
      for (int c = 0; c < 3; c++) begin
         num_in[c] = NUM_W'(prod_s6_ff[c]) + light_term;
      end
   end

   logic signed [NUM_W-1:0] num_s7_ff [3];
   logic [CHAN_W-1:0]       alpha_s7_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         num_s7_ff   <= num_in;
         alpha_s7_ff <= alpha_s6_ff;
      end
   end

   // ---------------- stage 8: rounding, clamping, output register
   logic [CHAN_W-1:0] level_in [3];

   for (genvar c = 0; c < 3; c++) begin : g_round
      hsl2rgb_round #(
         .NUM_W (NUM_W),
         .SHIFT (SHIFT)
      ) u_round (
         .num   (num_s7_ff[c]),
         .level (level_in[c])
      );
   end

   logic [CHAN_W-1:0] red_ff;
   logic [CHAN_W-1:0] green_ff;
   logic [CHAN_W-1:0] blue_ff;
   logic [CHAN_W-1:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[7]) begin
         red_ff   <= level_in[0];
         green_ff <= level_in[1];
         blue_ff  <= level_in[2];
         alpha_ff <= alpha_s7_ff;
      end
   end

   // ---------------- handshake control
   hsl2rgb_stage_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .ctl       (ctl)
   );

   assign rsp_tvalid = ctl.valid[hsl2rgb_pkg::STAGE_COUNT-1];
   assign rsp_tdata  = {alpha_ff, blue_ff, green_ff, red_ff};

   // Corrected remainder is always inside one turn
   `HSL2RGB_ASSERT_NOW(a_rem_range, clock, reset, ctl.valid[2], (rem_s3_ff < REM_W'(PERIOD)))
   // Sector and offset stay inside the six sectors
   `HSL2RGB_ASSERT_NOW(a_within_range, clock, reset, ctl.valid[3],
      ((within_s4_ff < WI_W'(SEC_W)) && (sector_s4_ff <= 3'd5)))
   // Off-sector hue sets every channel coefficient to minus the sector width
   `HSL2RGB_ASSERT_NOW(a_no_sector, clock, reset, (ctl.valid[4] && nosect_s5_ff),
      ((coef_s5_ff[0] == -CO_W'(SEC_W)) && (coef_s5_ff[1] == -CO_W'(SEC_W))
       && (coef_s5_ff[2] == -CO_W'(SEC_W))))

endmodule
